// ----- sv/timux_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timux_pkg
// shared types and constants of the two-image interlace mux
// ----------------------------------------------------------------------------
package timux_pkg;

    localparam int C_LANES  = 4;   // sample lanes on the ports
    localparam int C_PIX_W  = 16;  // port width of one sample
    localparam int C_IDX_W  = 3;   // register index width
    localparam int C_QDEPTH = 2;   // words held between front and back

    localparam logic [C_IDX_W-1:0] CFG_ROW_BAND       = 3'd0;
    localparam logic [C_IDX_W-1:0] CFG_COL_BAND       = 3'd1;
    localparam logic [C_IDX_W-1:0] CFG_LINE_WIDTH     = 3'd2;
    localparam logic [C_IDX_W-1:0] CFG_FIRST_BITS     = 3'd3;
    localparam logic [C_IDX_W-1:0] CFG_SECOND_BITS    = 3'd4;
    localparam logic [C_IDX_W-1:0] CFG_FIRST_SAMPLES  = 3'd5;
    localparam logic [C_IDX_W-1:0] CFG_SECOND_SAMPLES = 3'd6;

    typedef logic [C_LANES-1:0][C_PIX_W-1:0] t_lanes;

    typedef struct packed {
        logic [15:0] row_band;
        logic [15:0] col_band;
        logic [15:0] line_width;
        logic [4:0]  first_bits;
        logic [4:0]  second_bits;
        logic [2:0]  first_samples;
        logic [2:0]  second_samples;
    } t_cfg;

    // one classified pixel on its way to the rescale unit
    typedef struct packed {
        t_lanes               value;
        logic [C_LANES-1:0]   scale;
        logic [C_PIX_W-1:0]   src_max;
        logic [C_PIX_W-1:0]   dst_max;
        logic                 took_first;
        logic                 line_end;
    } t_job;

    typedef struct packed {
        t_lanes sample;
        logic   took_first;
        logic   line_end;
    } t_pix;

endpackage
`default_nettype wire

// ----- sv/timux_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timux_queue
// short fifo of classified words between the front and the rescale unit
// ----------------------------------------------------------------------------
module timux_queue
    import timux_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_push,
    input  wire  t_job i_job,
    output logic       o_full,
    input  wire  logic i_pop,
    output logic       o_valid,
    output t_job       o_job
);

    localparam int PW = (C_QDEPTH > 1) ? $clog2(C_QDEPTH) : 1;
    localparam int CW = $clog2(C_QDEPTH + 1);

    t_job            r_mem [C_QDEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(C_QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(C_QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_full  = (r_count == CW'(C_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

endmodule
`default_nettype wire

// ----- sv/timux_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timux_front
// band counters, source pick and per-lane classification of each pixel pair
// ----------------------------------------------------------------------------
module timux_front
    import timux_pkg::*;
#(
    parameter int MAX_SAMPLES  = 4,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire  logic   i_clk,
    input  wire  logic   i_rst_n,
    input  wire  t_cfg   i_cfg,
    input  wire  logic   i_valid,
    output logic         o_stall,
    input  wire  t_lanes i_a,
    input  wire  t_lanes i_b,
    input  wire  logic   i_frame_start,
    input  wire  logic   i_q_full,
    output logic         o_push,
    output t_job         o_job
);

    logic [15:0] r_col_pos, r_col_phase, r_row_phase;
    logic        r_col_par, r_row_par;
    logic [15:0] n_col_pos, n_col_phase, n_row_phase;
    logic        n_col_par, n_row_par;

    logic [15:0] cp, cph, rph;
    logic        cpar, rpar;
    logic        use_first, last;
    logic [4:0]  b1, b2, src_bits, dst_bits;
    logic [2:0]  n1, n2, src_n, dst_n;
    logic [16:0] src_max17, dst_max17;
    logic [15:0] src_max, dst_max, width, ph_inc;
    t_lanes      src;

    function automatic logic [4:0] fix_bits(input logic [4:0] b);
        logic [4:0] r;
        if (b == 5'd0) begin
            r = 5'd1;
        end else if (b > 5'(SAMPLE_WIDTH)) begin
            r = 5'(SAMPLE_WIDTH);
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [2:0] fix_count(input logic [2:0] n);
        logic [2:0] r;
        if (n == 3'd0) begin
            r = 3'd1;
        end else if (n > 3'(MAX_SAMPLES)) begin
            r = 3'(MAX_SAMPLES);
        end else begin
            r = n;
        end
        return r;
    endfunction

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        // frame start clears the counters before this pixel is judged
        cp   = i_frame_start ? 16'd0 : r_col_pos;
        cph  = i_frame_start ? 16'd0 : r_col_phase;
        cpar = i_frame_start ? 1'b0  : r_col_par;
        rph  = i_frame_start ? 16'd0 : r_row_phase;
        rpar = i_frame_start ? 1'b0  : r_row_par;

        priority if (i_cfg.row_band != '0 && i_cfg.col_band != '0) begin
            use_first = (rpar == cpar);
        end else if (i_cfg.row_band != '0) begin
            use_first = !rpar;
        end else if (i_cfg.col_band != '0) begin
            use_first = !cpar;
        end else begin
            use_first = 1'b1;
        end

        b1        = fix_bits(i_cfg.first_bits);
        b2        = fix_bits(i_cfg.second_bits);
        n1        = fix_count(i_cfg.first_samples);
        n2        = fix_count(i_cfg.second_samples);
        dst_bits  = (b1 > b2) ? b1 : b2;
        dst_n     = (n1 > n2) ? n1 : n2;
        src_bits  = use_first ? b1 : b2;
        src_n     = use_first ? n1 : n2;
        src       = use_first ? i_a : i_b;
        src_max17 = (17'd1 << src_bits) - 17'd1;
        dst_max17 = (17'd1 << dst_bits) - 17'd1;
        src_max   = src_max17[15:0];
        dst_max   = dst_max17[15:0];

        o_job.src_max    = src_max;
        o_job.dst_max    = dst_max;
        o_job.took_first = use_first;
        for (int i = 0; i < C_LANES; i++) begin
            if (3'(i) >= dst_n) begin
                o_job.value[i] = '0;
                o_job.scale[i] = 1'b0;
            end else if (3'(i) < src_n) begin
                o_job.value[i] = src[i] & src_max;
                o_job.scale[i] = 1'b1;
            end else begin
                o_job.value[i] = dst_max;
                o_job.scale[i] = 1'b0;
            end
        end

        width          = (i_cfg.line_width == '0) ? 16'd1 : i_cfg.line_width;
        last           = ({1'b0, cp} + 17'd1) >= {1'b0, width};
        o_job.line_end = last;

        n_col_pos   = cp;
        n_col_phase = cph;
        n_col_par   = cpar;
        n_row_phase = rph;
        n_row_par   = rpar;
        ph_inc      = '0;
        if (last) begin
            n_col_pos   = '0;
            n_col_phase = '0;
            n_col_par   = 1'b0;
            if (i_cfg.row_band == '0) begin
                n_row_phase = '0;
                n_row_par   = 1'b0;
            end else begin
                ph_inc = rph + 16'd1;
                if (ph_inc >= i_cfg.row_band) begin
                    n_row_phase = '0;
                    n_row_par   = !rpar;
                end else begin
                    n_row_phase = ph_inc;
                end
            end
        end else begin
            n_col_pos = cp + 16'd1;
            if (i_cfg.col_band == '0) begin
                n_col_phase = '0;
                n_col_par   = 1'b0;
            end else begin
                ph_inc = cph + 16'd1;
                if (ph_inc >= i_cfg.col_band) begin
                    n_col_phase = '0;
                    n_col_par   = !cpar;
                end else begin
                    n_col_phase = ph_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_col_phase <= '0;
            r_col_par   <= 1'b0;
            r_row_phase <= '0;
            r_row_par   <= 1'b0;
        end else if (o_push) begin
            r_col_pos   <= n_col_pos;
            r_col_phase <= n_col_phase;
            r_col_par   <= n_col_par;
            r_row_phase <= n_row_phase;
            r_row_par   <= n_row_par;
        end
    end

endmodule
`default_nettype wire

// ----- sv/timux_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timux_back
// depth rescale: v * dst_max + src_max / 2 divided by src_max, one quotient
// bit per cycle on all lanes at once, then the output register
// ----------------------------------------------------------------------------
module timux_back
    import timux_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_q_valid,
    input  wire  t_job i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  wire  logic i_stall,
    output t_pix       o_pix
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(SW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [CW-1:0]       r_cnt;
    logic [SW-1:0]       r_rem [C_LANES];
    logic [SW-1:0]       r_low [C_LANES];
    logic [SW-1:0]       r_quo [C_LANES];
    logic                r_ovalid;
    t_pix                r_opix;

    logic [2*SW-1:0]     num   [C_LANES];
    logic [SW-1:0]       n_rem [C_LANES];
    logic                q_bit [C_LANES];
    logic [SW:0]         trial [C_LANES];
    logic [SW:0]         dvs;
    logic                out_free;
    logic                load_out;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_ovalid || !i_stall;
    assign load_out = (r_state == S_OUT) && out_free;
    assign o_valid  = r_ovalid;
    assign o_pix    = r_opix;

    always_comb begin
        dvs = {1'b0, r_job.src_max[SW-1:0]};
        for (int i = 0; i < C_LANES; i++) begin
            num[i]   = (2*SW)'(r_job.value[i][SW-1:0]) * (2*SW)'(r_job.dst_max[SW-1:0])
                     + (2*SW)'(r_job.src_max[SW-1:1]);
            trial[i] = {r_rem[i], r_low[i][SW-1]};
            q_bit[i] = (trial[i] >= dvs);
            n_rem[i] = q_bit[i] ? SW'(trial[i] - dvs) : trial[i][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // remainder starts as the high half: quotient fits SW bits
                    for (int i = 0; i < C_LANES; i++) begin
                        r_rem[i] <= num[i][2*SW-1:SW];
                        r_low[i] <= num[i][SW-1:0];
                    end
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < C_LANES; i++) begin
                        r_rem[i] <= n_rem[i];
                        r_low[i] <= {r_low[i][SW-2:0], 1'b0};
                        r_quo[i] <= {r_quo[i][SW-2:0], q_bit[i]};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SW - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_opix.took_first <= r_job.took_first;
                        r_opix.line_end   <= r_job.line_end;
                        for (int i = 0; i < C_LANES; i++) begin
                            r_opix.sample[i] <= r_job.scale[i]
                                              ? C_PIX_W'(r_quo[i]) : r_job.value[i];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/two_image_interlace_mux_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_image_interlace_mux_unit
// picks one of two aligned pixels by row/column bands and rescales its depth
//
// input channel: i_valid / o_stall, one pixel pair per word, raster order,
// i_frame_start on the first pixel of a frame. output channel: o_valid /
// i_stall, one output pixel per input word, in order.
// the front takes a word whenever the two-entry queue has room, so it keeps
// accepting while the rescale unit works or a result waits to be taken.
// the bit-serial divider runs all four lanes together; the rescale unit takes
// no new word from the queue until its result has entered the output register.
// a word goes from the queue through the multiply and divide states to o_valid.
// a stalled result holds in the output register; the queue then fills and
// o_stall rises.
// reset clears band counters, queue and valids and loads the register
// defaults. the user writes registers through i_cfg_we / i_cfg_idx / i_cfg_data
// only while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_image_interlace_mux_unit
    import timux_pkg::*;
#(
    parameter int MAX_SAMPLES  = 4,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire  logic               i_clk,
    input  wire  logic               i_rst_n,
    input  wire  logic               i_cfg_we,
    input  wire  logic [C_IDX_W-1:0] i_cfg_idx,
    input  wire  logic [15:0]        i_cfg_data,
    input  wire  logic               i_valid,
    output logic                     o_stall,
    input  wire  logic [15:0]        i_a_s0,
    input  wire  logic [15:0]        i_a_s1,
    input  wire  logic [15:0]        i_a_s2,
    input  wire  logic [15:0]        i_a_s3,
    input  wire  logic [15:0]        i_b_s0,
    input  wire  logic [15:0]        i_b_s1,
    input  wire  logic [15:0]        i_b_s2,
    input  wire  logic [15:0]        i_b_s3,
    input  wire  logic               i_frame_start,
    output logic                     o_valid,
    input  wire  logic               i_stall,
    output logic [15:0]              o_out_s0,
    output logic [15:0]              o_out_s1,
    output logic [15:0]              o_out_s2,
    output logic [15:0]              o_out_s3,
    output logic                     o_took_first,
    output logic                     o_line_end
);

    t_cfg   r_cfg;
    t_lanes a_lanes, b_lanes;
    t_job   front_job, queue_job;
    t_pix   pix;
    logic   push, q_full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_band       <= 16'd1;
            r_cfg.col_band       <= 16'd0;
            r_cfg.line_width     <= 16'd1;
            r_cfg.first_bits     <= 5'd8;
            r_cfg.second_bits    <= 5'd8;
            r_cfg.first_samples  <= 3'd3;
            r_cfg.second_samples <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_BAND:       r_cfg.row_band       <= i_cfg_data;
                CFG_COL_BAND:       r_cfg.col_band       <= i_cfg_data;
                CFG_LINE_WIDTH:     r_cfg.line_width     <= i_cfg_data;
                CFG_FIRST_BITS:     r_cfg.first_bits     <= i_cfg_data[4:0];
                CFG_SECOND_BITS:    r_cfg.second_bits    <= i_cfg_data[4:0];
                CFG_FIRST_SAMPLES:  r_cfg.first_samples  <= i_cfg_data[2:0];
                CFG_SECOND_SAMPLES: r_cfg.second_samples <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign a_lanes = {i_a_s3, i_a_s2, i_a_s1, i_a_s0};
    assign b_lanes = {i_b_s3, i_b_s2, i_b_s1, i_b_s0};

    timux_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_a           (a_lanes),
        .i_b           (b_lanes),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    timux_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (queue_job)
    );

    timux_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (queue_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pix     (pix)
    );

    assign o_out_s0     = pix.sample[0];
    assign o_out_s1     = pix.sample[1];
    assign o_out_s2     = pix.sample[2];
    assign o_out_s3     = pix.sample[3];
    assign o_took_first = pix.took_first;
    assign o_line_end   = pix.line_end;

    // no alternation enabled: every word comes from the first image
    a_no_alt_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.row_band == '0 && r_cfg.col_band == '0)
        |-> o_took_first)
        else $error("second image chosen with alternation off");

    // one-pixel lines: every word ends its line
    a_short_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cfg.line_width == 16'd0 || r_cfg.line_width == 16'd1))
        |-> o_line_end)
        else $error("line end missing on one-pixel line");

    // at most three samples per pixel: top lane is unused and stays zero
    a_unused_lane_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.first_samples <= 3'd3 && r_cfg.second_samples <= 3'd3)
        |-> (o_out_s3 == 16'd0))
        else $error("unused sample lane not zero");

endmodule
`default_nettype wire
